// ===== design/pwli_pkg.sv =====
// ----------------------------------------------------------------------------
// Piecewise-linear schedule interpolator package
// Shared widths, codes, item types and helpers for the interpolator.
// ----------------------------------------------------------------------------
package pwli_pkg;

  // Default table depths.
  localparam int MAX_BREAKPOINTS_DEF = 16;
  localparam int MAX_COLORS_DEF      = 8;

  // Field widths.
  localparam int OP_W      = 2;
  localparam int ENTRY_W   = 4;
  localparam int COLOR_W   = 3;
  localparam int TIX_W     = 16;
  localparam int BPT_W     = 20;
  localparam int VAL_W     = 24;
  localparam int STEP_W    = 24;
  localparam int COUNT_W   = 5;
  localparam int RES_W     = 32;
  localparam int PROD_W    = TIX_W + STEP_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 24;

  // Register reset values.
  localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd65536;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd2;

  // Shared divider sizing.
  localparam int DIV_W     = 24;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] TN_DIV_STEPS   = 5'd20;
  localparam logic [DIV_CNT_W-1:0] LERP_DIV_STEPS = 5'd24;

  // Operation codes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_BP    = 2'd0,
    OP_LOAD_COLOR = 2'd1,
    OP_EVAL       = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 1'b0,
    CFG_BP_COUNT  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [ENTRY_W-1:0]        entry_index;
    logic [COLOR_W-1:0]        color;
    logic [TIX_W-1:0]          time_index;
    logic [BPT_W-1:0]          bp_time;
    logic signed [VAL_W-1:0]   bp_gamma;
    logic signed [VAL_W-1:0]   bp_js;
    logic [STEP_W-1:0]         color_period;
    logic signed [VAL_W-1:0]   color_scale;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0]          slice_time;
    logic signed [RES_W-1:0]   a_value;
    logic signed [RES_W-1:0]   b_value;
    logic                      out_of_range;
  } out_item_t;

  // Start request for the shared divider.
  typedef struct packed {
    logic                  start;
    logic [DIV_CNT_W-1:0]  iters;
    logic [DIV_W-1:0]      rem_init;
    logic [DIV_W-1:0]      low;
    logic [DIV_W-1:0]      divisor;
  } div_req_t;

  localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
  localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

  // Unsigned saturation of the slice time product to 32 bits.
  function automatic logic [RES_W-1:0] sat_u32(input logic [PROD_W-1:0] v);
    return (v[PROD_W-1:RES_W] != '0) ? '1 : v[RES_W-1:0];
  endfunction

  // Divide a Q.32 product by 65536 toward zero and saturate to 32 bits.
  function automatic logic [RES_W-1:0] scale_round(input logic signed [49:0] p);
    logic signed [49:0] biased;
    logic signed [49:0] shifted;
    biased  = p + $signed({34'd0, {16{p[49]}}});
    shifted = biased >>> 16;
    if (shifted > S32_MAX) begin
      return 32'h7FFF_FFFF;
    end
    if (shifted < S32_MIN) begin
      return 32'h8000_0000;
    end
    return shifted[RES_W-1:0];
  endfunction

endpackage

// ===== design/pwli_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface pwli_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== design/pwli_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pwli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/pwli_div.sv =====
// ----------------------------------------------------------------------------
// Shared serial divider
// Restoring division, one quotient bit per cycle, for a preloaded partial
// remainder and a word of low dividend bits shifted in from the top.
// ----------------------------------------------------------------------------
module pwli_div
  import pwli_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              busy_o,
  output logic [DIV_W-1:0]  quo_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q;
  logic [DIV_W-1:0]     low_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIV_W-1:0]     div_q;

  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 fits;
  logic [DIV_W-1:0]     rem_next;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial    = {rem_q, low_q[DIV_W-1]};
    diff     = trial - {1'b0, div_q};
    fits     = (trial >= {1'b0, div_q});
    rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  // Step counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.iters;
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Remainder, dividend and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      low_q <= req_i.low;
      div_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_next;
      low_q <= {low_q[DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== design/piecewise_linear_schedule_interp.sv =====
// ----------------------------------------------------------------------------
// Piecewise-linear schedule interpolator
// Load items are written to the tables in the cycle they are accepted. An
// evaluate item gets its normalized time from the serial divider (20 steps),
// walks the breakpoint RAM, one entry per cycle, to find its segment, and
// then interpolates each value on the divider (24 steps per value), except
// for a zero-width segment. An unusable color or a time that matches no
// segment gives an out-of-range result.
// One evaluate item is in work at a time. Reset clears the sequencer and the
// output register and loads the register defaults; the tables are undefined
// until loaded.
// ----------------------------------------------------------------------------
module piecewise_linear_schedule_interp
  import pwli_pkg::*;
#(
  parameter int MAX_BREAKPOINTS = MAX_BREAKPOINTS_DEF,
  parameter int MAX_COLORS      = MAX_COLORS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  pwli_stream_if.sink          in_ch_i,
  pwli_stream_if.source        out_ch_o
);

  localparam int BpAw    = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
  localparam int ColAw   = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int CntW    = $clog2(MAX_BREAKPOINTS + 1);
  localparam int BpEntW  = BPT_W + 2 * VAL_W;
  localparam int ColEntW = 2 * VAL_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_T,
    S_CHECK,
    S_DIV_T,
    S_SEARCH,
    S_L_MUL0,
    S_L_MUL1,
    S_L_ADD,
    S_L_DIV,
    S_SC_A,
    S_SC_B,
    S_SC_BW,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [STEP_W-1:0]  time_step_q;
  logic [COUNT_W-1:0] bp_count_q;

  // Item and datapath registers.
  logic [TIX_W-1:0]        tix_q;
  logic                    col_ok_q;
  logic [STEP_W-1:0]       period_q;
  logic signed [VAL_W-1:0] scale_q;
  logic [BPT_W-1:0]        tn_q;
  logic [CntW-1:0]         idx_q;
  logic [BPT_W-1:0]        t0_q;
  logic [BPT_W-1:0]        t1_q;
  logic signed [VAL_W-1:0] g0_q;
  logic signed [VAL_W-1:0] g1_q;
  logic signed [VAL_W-1:0] j0_q;
  logic signed [VAL_W-1:0] j1_q;
  logic                    first_q;
  logic signed [44:0]      acc_q;
  logic                    neg_q;
  logic signed [VAL_W-1:0] a_val_q;
  logic signed [VAL_W-1:0] b_val_q;
  logic [RES_W-1:0]        res_slice_q;
  logic [RES_W-1:0]        res_a_q;
  logic [RES_W-1:0]        res_b_q;
  logic                    res_oor_q;
  logic                    out_valid_q;
  out_item_t               out_item_q;
  logic signed [49:0]      mul_q;

  // Combinational helpers.
  logic                    accepted;
  logic                    bp_we;
  logic                    col_we;
  logic                    bp_re;
  logic [BpEntW-1:0]       bp_rdata;
  logic [ColEntW-1:0]      col_rdata;
  logic [BPT_W-1:0]        rd_time;
  logic signed [VAL_W-1:0] rd_gamma;
  logic signed [VAL_W-1:0] rd_js;
  logic [CntW-1:0]         n_eff;
  logic                    n_ok;
  logic [PROD_W-1:0]       prod;
  logic                    range_ok;
  logic [BPT_W-1:0]        wl;
  logic [BPT_W-1:0]        wr;
  logic [BPT_W-1:0]        seg_len;
  logic signed [44:0]      lerp_sum;
  logic [44:0]             lerp_mag;
  logic [VAL_W-1:0]        div_val;
  logic                    seg_hit;
  logic signed [24:0]      mul_a;
  logic signed [24:0]      mul_b;
  div_req_t                div_req;
  logic                    div_busy;
  logic [DIV_W-1:0]        div_quo;

  assign accepted = in_ch_i.valid && in_ch_i.ready;
  assign in_ch_i.ready = (state_q == S_IDLE);

  // Table writes happen in the cycle a load item is accepted.
  assign bp_we  = accepted && (in_ch_i.payload.operation == OP_LOAD_BP) &&
                  (in_ch_i.payload.entry_index < MAX_BREAKPOINTS);
  assign col_we = accepted && (in_ch_i.payload.operation == OP_LOAD_COLOR) &&
                  (in_ch_i.payload.color < MAX_COLORS);
  assign bp_re  = (state_q == S_SEARCH);

  pwli_ram #(
    .WIDTH (BpEntW),
    .DEPTH (MAX_BREAKPOINTS)
  ) u_bp_ram (
    .clk_i   (clk_i),
    .we_i    (bp_we),
    .waddr_i (BpAw'(in_ch_i.payload.entry_index)),
    .wdata_i ({in_ch_i.payload.bp_time, in_ch_i.payload.bp_gamma,
               in_ch_i.payload.bp_js}),
    .re_i    (bp_re),
    .raddr_i (idx_q[BpAw-1:0]),
    .rdata_o (bp_rdata)
  );

  pwli_ram #(
    .WIDTH (ColEntW),
    .DEPTH (MAX_COLORS)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (ColAw'(in_ch_i.payload.color)),
    .wdata_i ({in_ch_i.payload.color_period, in_ch_i.payload.color_scale}),
    .re_i    (accepted),
    .raddr_i (ColAw'(in_ch_i.payload.color)),
    .rdata_o (col_rdata)
  );

  pwli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  assign rd_time  = bp_rdata[BpEntW-1 -: BPT_W];
  assign rd_gamma = bp_rdata[2*VAL_W-1 -: VAL_W];
  assign rd_js    = bp_rdata[VAL_W-1:0];

  // Effective breakpoint count, clamped to the table depth.
  always_comb begin
    if (bp_count_q > MAX_BREAKPOINTS) begin
      n_eff = CntW'(MAX_BREAKPOINTS);
    end else begin
      n_eff = CntW'(bp_count_q);
    end
  end
  assign n_ok = (n_eff >= CntW'(2));

  // The normalized time fits in 20 bits exactly when prod < 16 * period.
  assign prod     = mul_q[PROD_W-1:0];
  assign range_ok = col_ok_q && (period_q != '0) && n_ok &&
                    (prod < {period_q, 4'b0000});

  // Segment weights and interpolation sum.
  assign wl       = t1_q - tn_q;
  assign wr       = tn_q - t0_q;
  assign seg_len  = t1_q - t0_q;
  assign lerp_sum = acc_q + $signed(mul_q[44:0]);
  assign lerp_mag = lerp_sum[44] ? (~lerp_sum + 45'd1) : lerp_sum;
  assign div_val  = neg_q ? (~div_quo + 24'd1) : div_quo;
  assign seg_hit  = (tn_q >= t0_q) && (tn_q <= rd_time);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL_T: begin
        mul_a = {9'd0, tix_q};
        mul_b = {1'b0, time_step_q};
      end
      S_L_MUL0: begin
        mul_a = {5'd0, wl};
        mul_b = first_q ? {g0_q[VAL_W-1], g0_q} : {j0_q[VAL_W-1], j0_q};
      end
      S_L_MUL1: begin
        mul_a = {5'd0, wr};
        mul_b = first_q ? {g1_q[VAL_W-1], g1_q} : {j1_q[VAL_W-1], j1_q};
      end
      S_SC_A: begin
        mul_a = {a_val_q[VAL_W-1], a_val_q};
        mul_b = {scale_q[VAL_W-1], scale_q};
      end
      S_SC_B: begin
        mul_a = {b_val_q[VAL_W-1], b_val_q};
        mul_b = {scale_q[VAL_W-1], scale_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier with its product register.
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // Divider start requests.
  always_comb begin
    div_req = '0;
    case (state_q)
      S_CHECK: begin
        div_req.start    = range_ok;
        div_req.iters    = TN_DIV_STEPS;
        div_req.rem_init = prod[27:4];
        div_req.low      = {prod[3:0], 20'd0};
        div_req.divisor  = period_q;
      end
      S_L_ADD: begin
        div_req.start    = 1'b1;
        div_req.iters    = LERP_DIV_STEPS;
        div_req.rem_init = {3'd0, lerp_mag[44:24]};
        div_req.low      = lerp_mag[23:0];
        div_req.divisor  = {4'd0, seg_len};
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_step_q <= STEP_RESET;
      bp_count_q  <= COUNT_RESET;
      tix_q       <= '0;
      col_ok_q    <= 1'b0;
      period_q    <= '0;
      scale_q     <= '0;
      tn_q        <= '0;
      idx_q       <= '0;
      t0_q        <= '0;
      t1_q        <= '0;
      g0_q        <= '0;
      g1_q        <= '0;
      j0_q        <= '0;
      j1_q        <= '0;
      first_q     <= 1'b0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      a_val_q     <= '0;
      b_val_q     <= '0;
      res_slice_q <= '0;
      res_a_q     <= '0;
      res_b_q     <= '0;
      res_oor_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TIME_STEP: time_step_q <= cfg_data_i[STEP_W-1:0];
          CFG_BP_COUNT:  bp_count_q  <= cfg_data_i[COUNT_W-1:0];
          default: begin
          end
        endcase
      end

      // The result register is loaded from the hand-off state and cleared
      // when the downstream side takes the waiting result.
      if ((state_q == S_OUT) && (!out_valid_q || out_ch_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accepted && (in_ch_i.payload.operation == OP_EVAL)) begin
            tix_q    <= in_ch_i.payload.time_index;
            col_ok_q <= (in_ch_i.payload.color < MAX_COLORS);
            state_q  <= S_MUL_T;
          end
        end
        S_MUL_T: begin
          period_q <= col_rdata[ColEntW-1 -: VAL_W];
          scale_q  <= col_rdata[VAL_W-1:0];
          state_q  <= S_CHECK;
        end
        S_CHECK: begin
          res_slice_q <= sat_u32(prod);
          if (range_ok) begin
            state_q <= S_DIV_T;
          end else begin
            res_a_q   <= '0;
            res_b_q   <= '0;
            res_oor_q <= 1'b1;
            state_q   <= S_OUT;
          end
        end
        S_DIV_T: begin
          if (!div_busy) begin
            tn_q    <= div_quo[BPT_W-1:0];
            idx_q   <= '0;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // Read data is registered, so entry idx-1 is here.
          if (idx_q == '0) begin
            idx_q <= idx_q + CntW'(1);
          end else if (idx_q == CntW'(1)) begin
            t0_q  <= rd_time;
            g0_q  <= rd_gamma;
            j0_q  <= rd_js;
            idx_q <= idx_q + CntW'(1);
          end else if (seg_hit) begin
            t1_q    <= rd_time;
            g1_q    <= rd_gamma;
            j1_q    <= rd_js;
            first_q <= 1'b1;
            res_oor_q <= 1'b0;
            if (rd_time == t0_q) begin
              // Zero-width segment takes the left breakpoint values.
              a_val_q <= g0_q;
              b_val_q <= j0_q;
              state_q <= S_SC_A;
            end else begin
              state_q <= S_L_MUL0;
            end
          end else begin
            t0_q <= rd_time;
            g0_q <= rd_gamma;
            j0_q <= rd_js;
            if (idx_q == n_eff) begin
              res_a_q   <= '0;
              res_b_q   <= '0;
              res_oor_q <= 1'b1;
              state_q   <= S_OUT;
            end else begin
              idx_q <= idx_q + CntW'(1);
            end
          end
        end
        S_L_MUL0: begin
          state_q <= S_L_MUL1;
        end
        S_L_MUL1: begin
          acc_q   <= mul_q[44:0];
          state_q <= S_L_ADD;
        end
        S_L_ADD: begin
          neg_q   <= lerp_sum[44];
          state_q <= S_L_DIV;
        end
        S_L_DIV: begin
          if (!div_busy) begin
            if (first_q) begin
              a_val_q <= div_val;
              first_q <= 1'b0;
              state_q <= S_L_MUL0;
            end else begin
              b_val_q <= div_val;
              state_q <= S_SC_A;
            end
          end
        end
        S_SC_A: begin
          state_q <= S_SC_B;
        end
        S_SC_B: begin
          res_a_q <= scale_round(mul_q);
          state_q <= S_SC_BW;
        end
        S_SC_BW: begin
          res_b_q <= scale_round(mul_q);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ch_o.ready) begin
            out_item_q.slice_time   <= res_slice_q;
            out_item_q.a_value      <= res_a_q;
            out_item_q.b_value      <= res_b_q;
            out_item_q.out_of_range <= res_oor_q;
            state_q                 <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch_o.valid   = out_valid_q;
  assign out_ch_o.payload = out_item_q;

  // A new result is only loaded from the result hand-off state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result appeared outside the hand-off state");

  // The shared divider is never restarted while it is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  // An out-of-range result carries zero values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.out_of_range) |->
      (out_item_q.a_value == '0) && (out_item_q.b_value == '0))
    else $error("out-of-range result with nonzero values");

  // The segment walk never runs past the effective breakpoint count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (idx_q <= n_eff))
    else $error("segment search ran past the table");

endmodule
